// ----- hdl/segment_pair_collision_check_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the segment pair collision check
// Implication and next-cycle implication checks, compiled out with ASSERT_OFF.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_PAIR_COLLISION_CHECK_ASSERT_SVH
`define SEGMENT_PAIR_COLLISION_CHECK_ASSERT_SVH
`ifndef ASSERT_OFF
`define SPPC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sppc assertion failed");
`define SPPC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sppc assertion failed");
`else
`define SPPC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SPPC_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- hdl/sppc_pkg.sv -----
// ----------------------------------------------------------------------------
// sppc_pkg
// Widths, codes, command/status structs and the product sequence table.
// ----------------------------------------------------------------------------
package sppc_pkg;

   localparam int COORD_BITS  = 32;
   localparam int FRAC_BITS   = 16;
   localparam int STEP_BITS   = 16;
   localparam int ID_BITS     = 8;
   localparam int RADIUS_BITS = 63;

   // coordinate difference, dot product, accumulator widths (signed)
   localparam int DW  = COORD_BITS + 1;
   localparam int OPW = 2 * COORD_BITS + 3;
   localparam int AW  = 2 * OPW + 2;

   // digit-serial multiplier
   localparam int DIGIT      = 17;
   localparam int NDIG_LONG  = (OPW + DIGIT - 1) / DIGIT;
   localparam int NDIG_SHORT = (DW + DIGIT - 1) / DIGIT;
   localparam int YW         = NDIG_LONG * DIGIT;
   localparam int PW         = OPW + YW;
   localparam int DCW        = $clog2(NDIG_LONG);

   // divider / parameters Q1.FRAC_BITS in [0,1]
   localparam int QW  = FRAC_BITS + 1;
   localparam int ICW = $clog2(FRAC_BITS);

   // closest-point product width
   localparam int PRW = QW + DW + 1;

   localparam int NPTS = 6;
   localparam int PTW  = $clog2(NPTS);

   // beat widths (already whole bytes)
   localparam int REQ_W = 6 * COORD_BITS + 2 * ID_BITS;
   localparam int RSP_W = 2 * ID_BITS + STEP_BITS + 6 * COORD_BITS;

   localparam int PCW = 5;
   localparam logic [PCW-1:0] PC_NUM_LAST = PCW'(20);
   localparam logic [PCW-1:0] PC_LAST     = PCW'(23);

   typedef enum logic [4:0] {
      OP_D1X, OP_D1Y, OP_D1Z,
      OP_D2X, OP_D2Y, OP_D2Z,
      OP_WX,  OP_WY,  OP_WZ,
      OP_A, OP_B, OP_C, OP_E, OP_F,
      OP_DDX, OP_DDY, OP_DDZ
   } opnd_type;

   typedef enum logic [3:0] {
      DST_NONE, DST_A, DST_B, DST_C, DST_E, DST_F,
      DST_DEN, DST_NS, DST_NT, DST_DIST
   } dst_type;

   typedef struct packed {
      opnd_type xsel;
      opnd_type ysel;
      logic     sub;
      logic     clear;
      logic     long_op;
      dst_type  dst;
   } mop_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL_LOAD, ST_MUL_RUN, ST_MUL_ACC,
      ST_DIV_INIT, ST_DIV_CHK, ST_DIV_RUN, ST_DIV_STORE,
      ST_POINT, ST_CHECK
   } state_type;

   typedef struct packed {
      logic           start_run;
      logic           capture;
      logic           mul_load;
      logic           mul_step;
      logic           mul_acc;
      mop_type        mop;
      logic           div_init;
      logic           div_chk;
      logic           div_step;
      logic           div_store;
      logic           div_sel;
      logic           pt_en;
      logic [PTW-1:0] pt_idx;
      logic           commit;
      logic           out_load;
   } cmd_type;

   typedef struct packed {
      logic div_more;
      logic hit;
      logic out_busy;
   } status_type;

   function automatic mop_type mk(input opnd_type x, input opnd_type y, input logic sub,
                                  input logic clr, input logic lng, input dst_type d);
      mop_type m;
      m.xsel    = x;
      m.ysel    = y;
      m.sub     = sub;
      m.clear   = clr;
      m.long_op = lng;
      m.dst     = d;
      return m;
   endfunction

   // dot products, then Cramer terms, then squared distance
   function automatic mop_type prog_op(input logic [PCW-1:0] pc);
      mop_type m;
      unique case (pc)
         5'd0:    m = mk(OP_D1X, OP_D1X, 1'b0, 1'b1, 1'b0, DST_NONE);
         5'd1:    m = mk(OP_D1Y, OP_D1Y, 1'b0, 1'b0, 1'b0, DST_NONE);
         5'd2:    m = mk(OP_D1Z, OP_D1Z, 1'b0, 1'b0, 1'b0, DST_A);
         5'd3:    m = mk(OP_D1X, OP_D2X, 1'b0, 1'b1, 1'b0, DST_NONE);
         5'd4:    m = mk(OP_D1Y, OP_D2Y, 1'b0, 1'b0, 1'b0, DST_NONE);
         5'd5:    m = mk(OP_D1Z, OP_D2Z, 1'b0, 1'b0, 1'b0, DST_B);
         5'd6:    m = mk(OP_D2X, OP_D2X, 1'b0, 1'b1, 1'b0, DST_NONE);
         5'd7:    m = mk(OP_D2Y, OP_D2Y, 1'b0, 1'b0, 1'b0, DST_NONE);
         5'd8:    m = mk(OP_D2Z, OP_D2Z, 1'b0, 1'b0, 1'b0, DST_C);
         5'd9:    m = mk(OP_WX,  OP_D1X, 1'b0, 1'b1, 1'b0, DST_NONE);
         5'd10:   m = mk(OP_WY,  OP_D1Y, 1'b0, 1'b0, 1'b0, DST_NONE);
         5'd11:   m = mk(OP_WZ,  OP_D1Z, 1'b0, 1'b0, 1'b0, DST_E);
         5'd12:   m = mk(OP_WX,  OP_D2X, 1'b0, 1'b1, 1'b0, DST_NONE);
         5'd13:   m = mk(OP_WY,  OP_D2Y, 1'b0, 1'b0, 1'b0, DST_NONE);
         5'd14:   m = mk(OP_WZ,  OP_D2Z, 1'b0, 1'b0, 1'b0, DST_F);
         5'd15:   m = mk(OP_B,   OP_B,   1'b0, 1'b1, 1'b1, DST_NONE);
         5'd16:   m = mk(OP_A,   OP_C,   1'b1, 1'b0, 1'b1, DST_DEN);
         5'd17:   m = mk(OP_E,   OP_C,   1'b0, 1'b1, 1'b1, DST_NONE);
         5'd18:   m = mk(OP_F,   OP_B,   1'b1, 1'b0, 1'b1, DST_NS);
         5'd19:   m = mk(OP_B,   OP_E,   1'b0, 1'b1, 1'b1, DST_NONE);
         5'd20:   m = mk(OP_A,   OP_F,   1'b1, 1'b0, 1'b1, DST_NT);
         5'd21:   m = mk(OP_DDX, OP_DDX, 1'b0, 1'b1, 1'b0, DST_NONE);
         5'd22:   m = mk(OP_DDY, OP_DDY, 1'b0, 1'b0, 1'b0, DST_NONE);
         5'd23:   m = mk(OP_DDZ, OP_DDZ, 1'b0, 1'b0, 1'b0, DST_DIST);
         default: m = mk(OP_D1X, OP_D1X, 1'b0, 1'b1, 1'b0, DST_NONE);
      endcase
      return m;
   endfunction

endpackage

// ----- hdl/sppc_ctrl.sv -----
// ----------------------------------------------------------------------------
// sppc_ctrl
// Sequencer: products, two divisions, closest points, hit check and commit.
// ----------------------------------------------------------------------------
module sppc_ctrl
   import sppc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_run_start,
   output logic       req_tready,
   output cmd_type    cmd,
   input  status_type status
);

   state_type      state_ff, state_in;
   logic [PCW-1:0] pc_ff, pc_in;
   logic [DCW-1:0] dcnt_ff, dcnt_in;
   logic [ICW-1:0] icnt_ff, icnt_in;
   logic [PTW-1:0] pcnt_ff, pcnt_in;
   logic           dsel_ff, dsel_in;
   logic           have_prev_ff, have_prev_in;
   mop_type        mop;
   logic [DCW-1:0] last_digit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= '0;
         dcnt_ff      <= '0;
         icnt_ff      <= '0;
         pcnt_ff      <= '0;
         dsel_ff      <= 1'b0;
         have_prev_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         dcnt_ff      <= dcnt_in;
         icnt_ff      <= icnt_in;
         pcnt_ff      <= pcnt_in;
         dsel_ff      <= dsel_in;
         have_prev_ff <= have_prev_in;
      end
   end

   always_comb begin
      mop        = prog_op(pc_ff);
      last_digit = mop.long_op ? DCW'(NDIG_LONG - 1) : DCW'(NDIG_SHORT - 1);

      state_in     = state_ff;
      pc_in        = pc_ff;
      dcnt_in      = dcnt_ff;
      icnt_in      = icnt_ff;
      pcnt_in      = pcnt_ff;
      dsel_in      = dsel_ff;
      have_prev_in = have_prev_ff;

      req_tready    = 1'b0;
      cmd           = '0;
      cmd.mop       = mop;
      cmd.div_sel   = dsel_ff;
      cmd.pt_idx    = pcnt_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               if (req_run_start || !have_prev_ff) begin
                  cmd.start_run = 1'b1;
                  have_prev_in  = 1'b1;
               end else begin
                  cmd.capture = 1'b1;
                  pc_in       = '0;
                  state_in    = ST_MUL_LOAD;
               end
            end
         end
         ST_MUL_LOAD: begin
            cmd.mul_load = 1'b1;
            dcnt_in      = '0;
            state_in     = ST_MUL_RUN;
         end
         ST_MUL_RUN: begin
            cmd.mul_step = 1'b1;
            dcnt_in      = dcnt_ff + 1'b1;
            if (dcnt_ff == last_digit) begin
               state_in = ST_MUL_ACC;
            end
         end
         ST_MUL_ACC: begin
            cmd.mul_acc = 1'b1;
            pc_in       = pc_ff + 1'b1;
            if (pc_ff == PC_NUM_LAST) begin
               dsel_in  = 1'b0;
               state_in = ST_DIV_INIT;
            end else if (pc_ff == PC_LAST) begin
               state_in = ST_CHECK;
            end else begin
               state_in = ST_MUL_LOAD;
            end
         end
         ST_DIV_INIT: begin
            cmd.div_init = 1'b1;
            state_in     = ST_DIV_CHK;
         end
         ST_DIV_CHK: begin
            cmd.div_chk = 1'b1;
            icnt_in     = '0;
            state_in    = status.div_more ? ST_DIV_RUN : ST_DIV_STORE;
         end
         ST_DIV_RUN: begin
            cmd.div_step = 1'b1;
            icnt_in      = icnt_ff + 1'b1;
            if (icnt_ff == ICW'(FRAC_BITS - 1)) begin
               state_in = ST_DIV_STORE;
            end
         end
         ST_DIV_STORE: begin
            cmd.div_store = 1'b1;
            if (!dsel_ff) begin
               dsel_in  = 1'b1;
               state_in = ST_DIV_INIT;
            end else begin
               pcnt_in  = '0;
               state_in = ST_POINT;
            end
         end
         ST_POINT: begin
            cmd.pt_en = 1'b1;
            pcnt_in   = pcnt_ff + 1'b1;
            // pc already sits on the distance products
            if (pcnt_ff == PTW'(NPTS - 1)) begin
               state_in = ST_MUL_LOAD;
            end
         end
         ST_CHECK: begin
            // a hit waits here while the previous result is still held
            if (!status.hit || !status.out_busy) begin
               cmd.commit   = 1'b1;
               cmd.out_load = status.hit;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- hdl/sppc_dp.sv -----
// ----------------------------------------------------------------------------
// sppc_dp
// Datapath: position store, digit-serial multiply-accumulate, restoring
// divider, closest-point unit, distance compare and result register.
// ----------------------------------------------------------------------------
module sppc_dp
   import sppc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_W-1:0]       req_tdata,
   input  logic                   csr_wen,
   input  logic [RADIUS_BITS-1:0] csr_wdata,
   input  cmd_type                cmd,
   output status_type             status,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_W-1:0]       rsp_tdata
);

   logic signed [COORD_BITS-1:0] in_pos [6];
   logic        [ID_BITS-1:0]    in_ida, in_idb;

   logic signed [COORD_BITS-1:0] prev_ff [6];
   logic signed [COORD_BITS-1:0] cur_ff [6];
   logic        [ID_BITS-1:0]    ida_ff, idb_ff;
   logic        [STEP_BITS-1:0]  step_ff;
   logic signed [DW-1:0]         d1_ff [3];
   logic signed [DW-1:0]         d2_ff [3];
   logic signed [DW-1:0]         wv_ff [3];
   logic signed [OPW-1:0]        a_ff, b_ff, c_ff, e_ff, f_ff;
   logic signed [AW-1:0]         den_ff, ns_ff, nt_ff, dist_ff, acc_ff;
   logic signed [AW-1:0]         acc_in, acc_base, pr_ext;
   logic        [OPW-1:0]        xmag_ff;
   logic        [YW-1:0]         ymag_ff, yload;
   logic                         pneg_ff;
   logic        [PW-1:0]         pr_ff;
   logic        [OPW+DIGIT-1:0]  pp;
   logic signed [OPW-1:0]        xop, yop;
   logic        [OPW-1:0]        xabs, yabs;
   logic signed [DW-1:0]         dd [3];

   logic        [AW-1:0]         rem_ff, dvs_ff, rem2;
   logic                         skip_ff;
   logic        [QW-1:0]         q_ff, s_ff, t_ff;
   logic signed [AW-1:0]         div_num;

   logic signed [COORD_BITS-1:0] p1_ff [3];
   logic signed [COORD_BITS-1:0] p2_ff [3];
   logic signed [COORD_BITS-1:0] pt_start;
   logic signed [DW-1:0]         pt_delta;
   logic        [QW-1:0]         pt_par;
   logic signed [PRW-1:0]        pt_prod, pt_sum;

   logic        [RADIUS_BITS-1:0] radius_ff;
   logic                          rsp_valid_ff;
   logic        [RSP_W-1:0]       rsp_data_ff;

   // input beat: six coordinates then the two ids
   always_comb begin
      for (int i = 0; i < 6; i++) begin
         in_pos[i] = $signed(req_tdata[i*COORD_BITS +: COORD_BITS]);
      end
      in_ida = req_tdata[6*COORD_BITS +: ID_BITS];
      in_idb = req_tdata[6*COORD_BITS + ID_BITS +: ID_BITS];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= '0;
      end else if (csr_wen) begin
         radius_ff <= csr_wdata;
      end
   end

   // positions, segment deltas, step index
   always_ff @(posedge clock) begin
      if (cmd.start_run) begin
         for (int i = 0; i < 6; i++) begin
            prev_ff[i] <= in_pos[i];
         end
         step_ff <= '0;
      end else if (cmd.commit) begin
         for (int i = 0; i < 6; i++) begin
            prev_ff[i] <= cur_ff[i];
         end
         step_ff <= step_ff + 1'b1;
      end
      if (cmd.capture) begin
         for (int i = 0; i < 6; i++) begin
            cur_ff[i] <= in_pos[i];
         end
         for (int i = 0; i < 3; i++) begin
            d1_ff[i] <= DW'(in_pos[i]) - DW'(prev_ff[i]);
            d2_ff[i] <= DW'(in_pos[i+3]) - DW'(prev_ff[i+3]);
            wv_ff[i] <= DW'(prev_ff[i]) - DW'(prev_ff[i+3]);
         end
         ida_ff <= in_ida;
         idb_ff <= in_idb;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dd[i] = DW'(p2_ff[i]) - DW'(p1_ff[i]);
      end
   end

   always_comb begin
      unique case (cmd.mop.xsel)
         OP_D1X:  xop = OPW'(d1_ff[0]);
         OP_D1Y:  xop = OPW'(d1_ff[1]);
         OP_D1Z:  xop = OPW'(d1_ff[2]);
         OP_D2X:  xop = OPW'(d2_ff[0]);
         OP_D2Y:  xop = OPW'(d2_ff[1]);
         OP_D2Z:  xop = OPW'(d2_ff[2]);
         OP_WX:   xop = OPW'(wv_ff[0]);
         OP_WY:   xop = OPW'(wv_ff[1]);
         OP_WZ:   xop = OPW'(wv_ff[2]);
         OP_A:    xop = a_ff;
         OP_B:    xop = b_ff;
         OP_C:    xop = c_ff;
         OP_E:    xop = e_ff;
         OP_F:    xop = f_ff;
         OP_DDX:  xop = OPW'(dd[0]);
         OP_DDY:  xop = OPW'(dd[1]);
         OP_DDZ:  xop = OPW'(dd[2]);
         default: xop = '0;
      endcase
   end

   always_comb begin
      unique case (cmd.mop.ysel)
         OP_D1X:  yop = OPW'(d1_ff[0]);
         OP_D1Y:  yop = OPW'(d1_ff[1]);
         OP_D1Z:  yop = OPW'(d1_ff[2]);
         OP_D2X:  yop = OPW'(d2_ff[0]);
         OP_D2Y:  yop = OPW'(d2_ff[1]);
         OP_D2Z:  yop = OPW'(d2_ff[2]);
         OP_WX:   yop = OPW'(wv_ff[0]);
         OP_WY:   yop = OPW'(wv_ff[1]);
         OP_WZ:   yop = OPW'(wv_ff[2]);
         OP_A:    yop = a_ff;
         OP_B:    yop = b_ff;
         OP_C:    yop = c_ff;
         OP_E:    yop = e_ff;
         OP_F:    yop = f_ff;
         OP_DDX:  yop = OPW'(dd[0]);
         OP_DDY:  yop = OPW'(dd[1]);
         OP_DDZ:  yop = OPW'(dd[2]);
         default: yop = '0;
      endcase
   end

   // sign-magnitude multiply, multiplier digits consumed from the top
   always_comb begin
      xabs = xop[OPW-1] ? OPW'(-xop) : OPW'(xop);
      yabs = yop[OPW-1] ? OPW'(-yop) : OPW'(yop);
      if (cmd.mop.long_op) begin
         yload = YW'(yabs);
      end else begin
         yload = YW'(yabs) << (DIGIT * (NDIG_LONG - NDIG_SHORT));
      end
      pp       = xmag_ff * ymag_ff[YW-1 -: DIGIT];
      acc_base = cmd.mop.clear ? '0 : acc_ff;
      pr_ext   = $signed(AW'(pr_ff));
      acc_in   = pneg_ff ? acc_base - pr_ext : acc_base + pr_ext;
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         xmag_ff <= xabs;
         ymag_ff <= yload;
         pneg_ff <= xop[OPW-1] ^ yop[OPW-1] ^ cmd.mop.sub;
         pr_ff   <= '0;
      end else if (cmd.mul_step) begin
         pr_ff   <= (pr_ff << DIGIT) + PW'(pp);
         ymag_ff <= ymag_ff << DIGIT;
      end
      if (cmd.mul_acc) begin
         acc_ff <= acc_in;
         unique case (cmd.mop.dst)
            DST_A:    a_ff    <= acc_in[OPW-1:0];
            DST_B:    b_ff    <= acc_in[OPW-1:0];
            DST_C:    c_ff    <= acc_in[OPW-1:0];
            DST_E:    e_ff    <= acc_in[OPW-1:0];
            DST_F:    f_ff    <= acc_in[OPW-1:0];
            DST_DEN:  den_ff  <= acc_in;
            DST_NS:   ns_ff   <= acc_in;
            DST_NT:   nt_ff   <= acc_in;
            DST_DIST: dist_ff <= acc_in;
            default: ;
         endcase
      end
   end

   // clamp(num/den, 0, 1) in Q1.FRAC_BITS, one quotient bit per cycle
   always_comb begin
      div_num = cmd.div_sel ? nt_ff : ns_ff;
      rem2    = rem_ff << 1;
   end

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff  <= div_num[AW-1] ? AW'(-div_num) : AW'(div_num);
         dvs_ff  <= den_ff[AW-1] ? AW'(-den_ff) : AW'(den_ff);
         skip_ff <= (den_ff == '0) || (div_num == '0) || (div_num[AW-1] != den_ff[AW-1]);
         q_ff    <= '0;
      end else if (cmd.div_chk) begin
         if (!skip_ff && rem_ff >= dvs_ff) begin
            q_ff <= QW'(1) << FRAC_BITS;
         end
      end else if (cmd.div_step) begin
         if (rem2 >= dvs_ff) begin
            rem_ff <= rem2 - dvs_ff;
            q_ff   <= {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_ff <= rem2;
            q_ff   <= {q_ff[QW-2:0], 1'b0};
         end
      end
      if (cmd.div_store) begin
         if (cmd.div_sel) begin
            t_ff <= q_ff;
         end else begin
            s_ff <= q_ff;
         end
      end
   end

   // closest point: start + floor(par * delta / 2^FRAC_BITS)
   always_comb begin
      unique case (cmd.pt_idx)
         3'd0:    begin pt_start = prev_ff[0]; pt_delta = d1_ff[0]; pt_par = s_ff; end
         3'd1:    begin pt_start = prev_ff[1]; pt_delta = d1_ff[1]; pt_par = s_ff; end
         3'd2:    begin pt_start = prev_ff[2]; pt_delta = d1_ff[2]; pt_par = s_ff; end
         3'd3:    begin pt_start = prev_ff[3]; pt_delta = d2_ff[0]; pt_par = t_ff; end
         3'd4:    begin pt_start = prev_ff[4]; pt_delta = d2_ff[1]; pt_par = t_ff; end
         default: begin pt_start = prev_ff[5]; pt_delta = d2_ff[2]; pt_par = t_ff; end
      endcase
      pt_prod = $signed({1'b0, pt_par}) * pt_delta;
      pt_sum  = PRW'(pt_start) + (pt_prod >>> FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (cmd.pt_en) begin
         unique case (cmd.pt_idx)
            3'd0:    p1_ff[0] <= pt_sum[COORD_BITS-1:0];
            3'd1:    p1_ff[1] <= pt_sum[COORD_BITS-1:0];
            3'd2:    p1_ff[2] <= pt_sum[COORD_BITS-1:0];
            3'd3:    p2_ff[0] <= pt_sum[COORD_BITS-1:0];
            3'd4:    p2_ff[1] <= pt_sum[COORD_BITS-1:0];
            default: p2_ff[2] <= pt_sum[COORD_BITS-1:0];
         endcase
      end
   end

   // distance is never negative; anything at or above 2^63 misses
   always_comb begin
      status.div_more = !skip_ff && (rem_ff < dvs_ff);
      status.hit      = (dist_ff[AW-1:RADIUS_BITS] == '0) &&
                        (dist_ff[RADIUS_BITS-1:0] < radius_ff);
      status.out_busy = rsp_valid_ff && !rsp_tready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= {p2_ff[2], p2_ff[1], p2_ff[0], p1_ff[2], p1_ff[1], p1_ff[0],
                         step_ff, idb_ff, ida_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ----- hdl/segment_pair_collision_check.sv -----
// ----------------------------------------------------------------------------
// segment_pair_collision_check
// Closest approach of two agents' motion segments with a radius check.
// ----------------------------------------------------------------------------
//  port group  | dir | beat content
//  req_*       | in  | tdata: first_x,y,z, second_x,y,z, agent_a, agent_b; tuser: run_start
//  rsp_*       | out | tdata: ids, segment_index, near_first_x,y,z, near_second_x,y,z
//  csr_*       | in  | radius_sq write, Q31.32
//
//  A segment beat runs 24 products on the shared 67x17 digit multiplier,
//  two restoring divisions of up to 16 steps, six closest-point coordinates
//  and a check.
//  Reset clears the sequencer, the result valid and radius_sq.
//  A result waits in the output register while the next beat is worked on; a
//  second hit holds the sequencer until the first one is taken.
// ----------------------------------------------------------------------------
`include "segment_pair_collision_check_assert.svh"

module segment_pair_collision_check
   import sppc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [31:0] first_x, [63:32] first_y, [95:64] first_z, [127:96] second_x,
   // [159:128] second_y, [191:160] second_z, [199:192] agent_a, [207:200] agent_b
   input  logic [REQ_W-1:0]       req_tdata,
   // [0] run_start
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [7:0] hit_agent_a, [15:8] hit_agent_b, [31:16] segment_index,
   // [63:32] near_first_x, [95:64] near_first_y, [127:96] near_first_z,
   // [159:128] near_second_x, [191:160] near_second_y, [223:192] near_second_z
   output logic [RSP_W-1:0]       rsp_tdata,
   input  logic                   csr_wen,
   input  logic [RADIUS_BITS-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;
   logic [10:0] dp_ops;

   sppc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_run_start (req_tuser),
      .req_tready    (req_tready),
      .cmd           (cmd),
      .status        (status)
   );

   sppc_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assign dp_ops = {cmd.start_run, cmd.capture, cmd.mul_load, cmd.mul_step, cmd.mul_acc,
                    cmd.div_init, cmd.div_chk, cmd.div_step, cmd.div_store, cmd.pt_en,
                    cmd.commit};

   `SPPC_ASSERT_NXT(a_busy_after_capture, clock, reset, cmd.capture, !req_tready)
   `SPPC_ASSERT_IMP(a_no_result_overwrite, clock, reset, cmd.out_load, !status.out_busy)
   `SPPC_ASSERT_IMP(a_one_dp_op, clock, reset, 1'b1, $onehot0(dp_ops))

endmodule

// ----- verif/tb_segment_pair_collision_check.sv -----
// ----------------------------------------------------------------------------
// Testbench for segment_pair_collision_check
// Drives agent position beats with random gaps and receiver stalls. A wide
// integer model of the closest-approach solve predicts each collision beat,
// and every result beat is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
module tb_segment_pair_collision_check
   import sppc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  UNIT       = 65536;
   localparam int  CYCLE_CAP  = 3000000;
   localparam int  SETTLE     = 250;
   localparam int  LONG_HOLD  = 3000;

   typedef logic signed [255:0] big_type;

   // pos[0..2] first agent xyz, pos[3..5] second agent xyz
   typedef struct packed {
      logic                  run_start;
      logic [7:0]            agent_b;
      logic [7:0]            agent_a;
      logic [5:0][31:0]      pos;
   } step_type;

   // near[0..2] first segment point, near[3..5] second segment point
   typedef struct packed {
      logic [5:0][31:0]      near;
      logic [15:0]           seg_index;
      logic [7:0]            agent_b;
      logic [7:0]            agent_a;
   } hit_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_W-1:0]       rsp_tdata;
   logic                   csr_wen = 1'b0;
   logic [RADIUS_BITS-1:0] csr_wdata = '0;

   segment_pair_collision_check dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   always #10 clock = ~clock;

   step_type pending_steps[$];
   hit_type  expected_hits[$];
   int    fail_count = 0;
   int    cycle_count = 0;
   bit    quiet = 1'b0;
   bit    hold_request = 1'b0;
   bit    hold_done = 1'b0;
   bit    req_taken = 1'b0;
   bit    rsp_taken = 1'b0;

   // predictor state
   logic [62:0] radius_model = '0;
   big_type     prev_pos[6];
   bit          have_prev = 1'b0;
   logic [15:0] step_model = '0;

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
      fail_count++;
   endtask

   function automatic logic [63:0] clamp_ratio(input big_type num, input big_type den);
      big_type r, d;
      if (num == 0 || num[255] != den[255]) return 64'd0;
      r = num[255] ? -num : num;
      d = den[255] ? -den : den;
      if (r >= d) return 64'd1 << FRAC_BITS;
      return 64'((r <<< FRAC_BITS) / d);
   endfunction

   function automatic big_type dot(input big_type x0, x1, x2, y0, y1, y2);
      return x0 * y0 + x1 * y1 + x2 * y2;
   endfunction

   // returns 1 when the step produces a collision beat
   function automatic bit closest_approach(input step_type it, output hit_type h);
      big_type cur[6], d1[3], d2[3], w[3];
      big_type a, b, c, e, f, den, dsq, p1, p2, dd;
      logic [63:0] s, t, dsat;
      bit hit;
      h = '0;
      s = '0;
      t = '0;
      for (int i = 0; i < 6; i++) cur[i] = big_type'($signed(it.pos[i]));
      if (it.run_start || !have_prev) begin
         for (int i = 0; i < 6; i++) prev_pos[i] = cur[i];
         have_prev = 1'b1;
         step_model = '0;
         return 1'b0;
      end
      for (int i = 0; i < 3; i++) begin
         d1[i] = cur[i] - prev_pos[i];
         d2[i] = cur[i+3] - prev_pos[i+3];
         w[i]  = prev_pos[i] - prev_pos[i+3];
      end
      a = dot(d1[0], d1[1], d1[2], d1[0], d1[1], d1[2]);
      b = dot(d1[0], d1[1], d1[2], d2[0], d2[1], d2[2]);
      c = dot(d2[0], d2[1], d2[2], d2[0], d2[1], d2[2]);
      e = dot(w[0], w[1], w[2], d1[0], d1[1], d1[2]);
      f = dot(w[0], w[1], w[2], d2[0], d2[1], d2[2]);
      den = b * b - a * c;
      if (den != 0) begin
         s = clamp_ratio(e * c - f * b, den);
         t = clamp_ratio(b * e - a * f, den);
      end
      dsq = 0;
      for (int i = 0; i < 3; i++) begin
         // floor(param * delta / 2^FRAC) keeps the point on the segment
         p1 = prev_pos[i] + ((big_type'(s) * d1[i]) >>> FRAC_BITS);
         p2 = prev_pos[i+3] + ((big_type'(t) * d2[i]) >>> FRAC_BITS);
         dd = p2 - p1;
         dsq = dsq + dd * dd;
         h.near[i]   = p1[31:0];
         h.near[i+3] = p2[31:0];
      end
      dsat = (dsq > big_type'(64'h7FFF_FFFF_FFFF_FFFF)) ?
             64'h7FFF_FFFF_FFFF_FFFF : dsq[63:0];
      hit = dsat < {1'b0, radius_model};
      h.agent_a = it.agent_a;
      h.agent_b = it.agent_b;
      h.seg_index = step_model;
      for (int i = 0; i < 6; i++) prev_pos[i] = cur[i];
      step_model = step_model + 16'd1;
      return hit;
   endfunction

   // sampling side: predictor, checker, register shadow
   always @(posedge clock) begin
      hit_type h, got, want;
      cycle_count <= cycle_count + 1;
      req_taken <= !reset && req_tvalid && req_tready;
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
      if (!reset) begin
         if (csr_wen) radius_model = csr_wdata;
         if (req_tvalid && req_tready) begin
            if (closest_approach(step_type'({req_tuser, req_tdata}), h))
               expected_hits.insert(expected_hits.size(), h);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = hit_type'(rsp_tdata);
            if (expected_hits.size() == 0) begin
               report("unexpected result beat", rsp_tdata[31:0], 32'd0);
            end else begin
               want = expected_hits.pop_front();
               if (got.agent_a !== want.agent_a) report("hit_agent_a", got.agent_a, want.agent_a);
               if (got.agent_b !== want.agent_b) report("hit_agent_b", got.agent_b, want.agent_b);
               if (got.seg_index !== want.seg_index)
                  report("segment_index", got.seg_index, want.seg_index);
               for (int i = 0; i < 6; i++) begin
                  if (got.near[i] !== want.near[i])
                     report($sformatf("near point %0d", i), got.near[i], want.near[i]);
               end
            end
         end
      end
      if (cycle_count > CYCLE_CAP) begin
         $display("timeout");
         $display("FAILURE");
         $finish;
      end
   end

   // sender
   int tx_wait = 0;
   always @(negedge clock) begin
      step_type it;
      logic  nxt_valid;
      nxt_valid = req_tvalid;
      if (reset) begin
         nxt_valid = 1'b0;
      end else if (req_tvalid && !req_taken) begin
         nxt_valid = 1'b1;
      end else if (tx_wait > 0) begin
         tx_wait--;
         nxt_valid = 1'b0;
      end else if (pending_steps.size() > 0) begin
         it = pending_steps.pop_front();
         req_tdata <= {it.agent_b, it.agent_a, it.pos};
         req_tuser <= it.run_start;
         nxt_valid = 1'b1;
         tx_wait = quiet ? 0 : $urandom_range(0, 12);
      end else begin
         nxt_valid = 1'b0;
      end
      req_tvalid <= nxt_valid;
   end

   // receiver, with one long hold-off on request
   int rx_wait = 0;
   int hold_cnt = 0;
   always @(negedge clock) begin
      logic rdy;
      if (reset) begin
         rdy = 1'b0;
      end else begin
         if (hold_request && !hold_done) begin
            hold_cnt = LONG_HOLD;
            hold_done = 1'b1;
         end
         if (rsp_taken && !quiet) rx_wait = $urandom_range(0, 12);
         if (hold_cnt > 0) begin
            hold_cnt--;
            rdy = 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rdy = 1'b0;
         end else begin
            rdy = 1'b1;
         end
      end
      rsp_tready <= rdy;
   end

   function automatic void add_step(input int ax, ay, az, bx, by, bz, input bit rs);
      step_type it;
      it.pos = {32'(bz), 32'(by), 32'(bx), 32'(az), 32'(ay), 32'(az) ^ 32'(az) ^ 32'(ax)};
      it.pos[1] = 32'(ay);
      it.pos[2] = 32'(az);
      it.agent_a = $urandom_range(0, 255);
      it.agent_b = $urandom_range(0, 255);
      it.run_start = rs;
      pending_steps.insert(pending_steps.size(), it);
   endfunction

   function automatic int pick_extreme();
      case ($urandom_range(0, 4))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 0;
         3: return -1;
         default: return 1;
      endcase
   endfunction

   // a trajectory pair that stays close, plus some noise beats
   function automatic void add_random(input int count);
      int ax, ay, az, bx, by, bz, len;
      step_type it;
      for (int n = 0; n < count; ) begin
         if ($urandom_range(0, 4) != 0) begin
            ax = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
            ay = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
            az = $signed($urandom_range(0, 1 << 23)) - (1 << 22);
            bx = ax + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            by = ay + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            bz = az + $signed($urandom_range(0, 1 << 21)) - (1 << 20);
            len = $urandom_range(2, 8);
            for (int k = 0; k < len; k++) begin
               add_step(ax, ay, az, bx, by, bz, k == 0);
               ax += $signed($urandom_range(0, 1 << 19)) - (1 << 18);
               ay += $signed($urandom_range(0, 1 << 19)) - (1 << 18);
               az += $signed($urandom_range(0, 1 << 19)) - (1 << 18);
               bx += $signed($urandom_range(0, 1 << 19)) - (1 << 18);
               by += $signed($urandom_range(0, 1 << 19)) - (1 << 18);
               bz += $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            end
            n += len;
         end else begin
            for (int i = 0; i < 6; i++) it.pos[i] = $urandom;
            it.agent_a = $urandom_range(0, 255);
            it.agent_b = $urandom_range(0, 255);
            it.run_start = ($urandom_range(0, 3) == 0);
            pending_steps.insert(pending_steps.size(), it);
            n++;
         end
      end
   endfunction

   task automatic drain();
      while (pending_steps.size() > 0 || req_tvalid || expected_hits.size() > 0)
         @(posedge clock);
      // steps without a hit may still be in flight
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_radius(input logic [62:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   initial begin
      logic [62:0] radius_set[5];
      radius_set = '{63'h0, 63'h7FFF_FFFF_FFFF_FFFF, 63'd1 << 40,
                     63'({$urandom, $urandom}), 63'd1 << 34};
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      write_radius(63'd1 << 40);
      // first beat after reset opens a run even without run_start
      add_step(0, 0, 0, 0, 0, 0, 1'b0);
      add_step(0, 0, 0, 0, 0, 0, 1'b0);                    // both stationary, zero det
      add_step(-UNIT, 0, 0, 0, -UNIT, UNIT, 1'b1);
      add_step(UNIT, 0, 0, 0, UNIT, UNIT, 1'b0);           // crossing segments
      add_step(UNIT, 2*UNIT, 0, 3*UNIT, 2*UNIT, 0, 1'b0);  // skew segments
      add_step(9*UNIT, 2*UNIT, UNIT, -5*UNIT, 7*UNIT, 0, 1'b0); // params inside the segments
      add_step(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0); // distance saturates
      add_step(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      add_step(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 32'h8000_0000, 1'b0);
      add_step(32'h8000_0000, -1, 1, 32'h8000_0000, -1, 1, 1'b1);
      add_step(32'h8000_0000, -1, 1, 32'h8000_0001, -1, 1, 1'b0);
      for (int k = 0; k < 10; k++)
         add_step(pick_extreme(), pick_extreme(), pick_extreme(),
                  pick_extreme(), pick_extreme(), pick_extreme(), k == 0);
      drain();

      for (int p = 0; p < 5; p++) begin
         write_radius(radius_set[p]);
         quiet = (p == 2);
         if (p == 1) hold_request = 1'b1;
         add_random(160);
         drain();
      end

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
